@@ hw/rtl/bsp_pkg.sv @@
package bsp_pkg;

	// Storage geometry
	localparam int CAPACITY     = 8;
	localparam int KEY_BITS     = 40;
	localparam int PAYLOAD_BITS = 16;
	localparam int CNT_W        = $clog2(CAPACITY + 1);

	// Fixed field widths on the channels
	localparam int OP_W        = 2;
	localparam int KEY_FIELD_W = 40;
	localparam int PAY_FIELD_W = 16;
	localparam int CNT_FIELD_W = 4;
	localparam int STATUS_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// What a cell loads at the next edge
	typedef enum logic [1:0] {
		ACT_HOLD       = 2'd0,
		ACT_LOAD_NEW   = 2'd1,
		ACT_TAKE_LEFT  = 2'd2,
		ACT_TAKE_RIGHT = 2'd3
	} cell_act_t;

	typedef struct packed {
		logic      en;
		cell_act_t act;
	} cell_ctl_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]     key;
		logic [PAYLOAD_BITS-1:0] payload;
	} entry_t;

	typedef struct packed {
		status_t                status;
		logic                   removed_valid;
		logic [KEY_FIELD_W-1:0] removed_key;
		logic [PAY_FIELD_W-1:0] removed_payload;
		logic [CNT_FIELD_W-1:0] entry_count;
		logic                   is_full;
		logic                   is_empty;
	} result_t;

	// Field to stored width: truncate or zero-extend
	function automatic logic [KEY_BITS-1:0] key_from_field(logic [KEY_FIELD_W-1:0] f);
		logic [63:0] w;
		w = 64'(f);
		return w[KEY_BITS-1:0];
	endfunction

	function automatic logic [KEY_FIELD_W-1:0] key_to_field(logic [KEY_BITS-1:0] k);
		logic [63:0] w;
		w = 64'(k);
		return w[KEY_FIELD_W-1:0];
	endfunction

	function automatic logic [PAYLOAD_BITS-1:0] pay_from_field(logic [PAY_FIELD_W-1:0] f);
		logic [63:0] w;
		w = 64'(f);
		return w[PAYLOAD_BITS-1:0];
	endfunction

	function automatic logic [PAY_FIELD_W-1:0] pay_to_field(logic [PAYLOAD_BITS-1:0] p);
		logic [63:0] w;
		w = 64'(p);
		return w[PAY_FIELD_W-1:0];
	endfunction

	function automatic logic [CNT_FIELD_W-1:0] cnt_to_field(logic [CNT_W-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[CNT_FIELD_W-1:0];
	endfunction

endpackage

@@ hw/rtl/bsp_req_if.sv @@
interface bsp_req_if;
	logic                            valid;
	logic                            ready;
	logic [bsp_pkg::OP_W-1:0]        op;
	logic [bsp_pkg::KEY_FIELD_W-1:0] entry_key;
	logic [bsp_pkg::PAY_FIELD_W-1:0] entry_payload;

	modport source (output valid, output op, output entry_key, output entry_payload,
		input ready);
	modport sink (input valid, input op, input entry_key, input entry_payload,
		output ready);
endinterface

@@ hw/rtl/bsp_rsp_if.sv @@
interface bsp_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [bsp_pkg::STATUS_W-1:0]    status;
	logic                            removed_valid;
	logic [bsp_pkg::KEY_FIELD_W-1:0] removed_key;
	logic [bsp_pkg::PAY_FIELD_W-1:0] removed_payload;
	logic [bsp_pkg::CNT_FIELD_W-1:0] entry_count;
	logic                            is_full;
	logic                            is_empty;

	modport source (output valid, output status, output removed_valid, output removed_key,
		output removed_payload, output entry_count, output is_full, output is_empty,
		input ready);
	modport sink (input valid, input status, input removed_valid, input removed_key,
		input removed_payload, input entry_count, input is_full, input is_empty,
		output ready);
endinterface

@@ hw/rtl/bsp_cell.sv @@
module bsp_cell (
	input  logic               clk,
	input  bsp_pkg::cell_ctl_t ctl,
	input  bsp_pkg::entry_t    new_entry,
	input  bsp_pkg::entry_t    left_entry,
	input  bsp_pkg::entry_t    right_entry,
	output bsp_pkg::entry_t    entry,
	output logic               le
);

	bsp_pkg::entry_t entry_q;

	// Compare the held key against the incoming one
	assign le    = entry_q.key <= new_entry.key;
	assign entry = entry_q;

	// Hold, take the new word, or shift from a neighbor
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			case (ctl.act)
				bsp_pkg::ACT_HOLD:       entry_q <= entry_q;
				bsp_pkg::ACT_LOAD_NEW:   entry_q <= new_entry;
				bsp_pkg::ACT_TAKE_LEFT:  entry_q <= left_entry;
				bsp_pkg::ACT_TAKE_RIGHT: entry_q <= right_entry;
				default:                 entry_q <= entry_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/bounded_sorted_priority_queue_top.sv @@
// Sorted priority queue of bsp_pkg::CAPACITY entries held in a row of compare-and-shift
// cells, smallest key in cell 0; equal keys leave in arrival order. Each request word
// (enqueue, dequeue, clear) is taken and its response word appears in the output
// register at the next edge, so the block sustains one request per cycle while the
// receiver keeps taking responses: every cell compares its key with the new one and
// shifts at that same edge. A request is held back only while a response waits untaken.
// Slot contents are not reset; only the entry count and the response valid flag are.
module bounded_sorted_priority_queue_top (
	input  logic clk,
	input  logic arst_n,
	bsp_req_if.sink   req,
	bsp_rsp_if.source rsp
);

	localparam int CAP = bsp_pkg::CAPACITY;
	localparam int CW  = bsp_pkg::CNT_W;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               rsp_valid_q;
	bsp_pkg::result_t   rsp_q;
	bsp_pkg::result_t   result;
	bsp_pkg::entry_t    new_entry;
	bsp_pkg::entry_t    cell_entry [CAP];
	bsp_pkg::cell_ctl_t cell_ctl   [CAP];
	logic [CAP-1:0]     cell_le;
	logic [CAP-1:0]     stay;
	logic [CAP-1:0]     stay_prev;
	logic               accept;
	logic               enq_ok;
	logic               deq_ok;
	bsp_pkg::op_t       op;

	assign op        = bsp_pkg::op_t'(req.op);
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign enq_ok    = (op == bsp_pkg::OP_ENQUEUE) && (count_q < CW'(CAP));
	assign deq_ok    = (op == bsp_pkg::OP_DEQUEUE) && (count_q != '0);

	assign new_entry.key     = bsp_pkg::key_from_field(req.entry_key);
	assign new_entry.payload = bsp_pkg::pay_from_field(req.entry_payload);

	// Decide per cell: occupied cells with key <= new hold, the first other takes
	// the new word, the rest shift right; dequeue shifts everything left
	always_comb begin
		for (int i = 0; i < CAP; i++) begin
			stay[i] = (CW'(i) < count_q) && cell_le[i];
		end
		stay_prev[0] = 1'b1;
		for (int i = 1; i < CAP; i++) begin
			stay_prev[i] = stay[i-1];
		end
		for (int i = 0; i < CAP; i++) begin
			cell_ctl[i].en = accept && (enq_ok || deq_ok);
			if (deq_ok) begin
				cell_ctl[i].act = bsp_pkg::ACT_TAKE_RIGHT;
			end else if (stay[i]) begin
				cell_ctl[i].act = bsp_pkg::ACT_HOLD;
			end else if (stay_prev[i]) begin
				cell_ctl[i].act = bsp_pkg::ACT_LOAD_NEW;
			end else begin
				cell_ctl[i].act = bsp_pkg::ACT_TAKE_LEFT;
			end
		end
	end

	// Row of cells with neighbor links
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		bsp_pkg::entry_t left_entry;
		bsp_pkg::entry_t right_entry;

		if (g == 0) begin : g_first
			assign left_entry = new_entry;
		end else begin : g_mid
			assign left_entry = cell_entry[g-1];
		end
		if (g == CAP - 1) begin : g_last
			assign right_entry = cell_entry[g];
		end else begin : g_inner
			assign right_entry = cell_entry[g+1];
		end

		bsp_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[g]),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[g]),
			.le          (cell_le[g])
		);
	end

	// Build the response word and the next count
	always_comb begin
		count_next             = count_q;
		result.status          = bsp_pkg::ST_DONE;
		result.removed_valid   = 1'b0;
		result.removed_key     = '0;
		result.removed_payload = '0;
		case (op)
			bsp_pkg::OP_ENQUEUE: begin
				if (enq_ok) begin
					count_next = count_q + CW'(1);
				end else begin
					result.status = bsp_pkg::ST_FULL;
				end
			end
			bsp_pkg::OP_DEQUEUE: begin
				if (deq_ok) begin
					count_next             = count_q - CW'(1);
					result.removed_valid   = 1'b1;
					result.removed_key     = bsp_pkg::key_to_field(cell_entry[0].key);
					result.removed_payload = bsp_pkg::pay_to_field(cell_entry[0].payload);
				end else begin
					result.status = bsp_pkg::ST_EMPTY;
				end
			end
			bsp_pkg::OP_CLEAR: count_next = '0;
			default:           count_next = count_q;
		endcase
		result.entry_count = bsp_pkg::cnt_to_field(count_next);
		result.is_full     = count_next == CW'(CAP);
		result.is_empty    = count_next == '0;
	end

	// Advance the count and the response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response word
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.removed_valid   = rsp_q.removed_valid;
	assign rsp.removed_key     = rsp_q.removed_key;
	assign rsp.removed_payload = rsp_q.removed_payload;
	assign rsp.entry_count     = rsp_q.entry_count;
	assign rsp.is_full         = rsp_q.is_full;
	assign rsp.is_empty        = rsp_q.is_empty;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAP))
		else $error("entry count above capacity");

	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request without response");

	a_full_reject: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (op == bsp_pkg::OP_ENQUEUE) && (count_q == CW'(CAP)) |=>
		(rsp_q.status == bsp_pkg::ST_FULL) && $stable(count_q))
		else $error("enqueue on full queue not rejected");

	a_removed_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.removed_valid |-> (rsp_q.status == bsp_pkg::ST_DONE) &&
		!rsp_q.is_full)
		else $error("removed entry with bad status");
`endif

endmodule

@@ dv/tb_bounded_sorted_priority_queue_top.sv @@
`timescale 1ns / 1ps

module tb_bounded_sorted_priority_queue_top;
	import bsp_pkg::*;

	localparam logic [KEY_FIELD_W-1:0] KEY_MAX = {KEY_FIELD_W{1'b1}};
	localparam logic [PAY_FIELD_W-1:0] PAY_MAX = {PAY_FIELD_W{1'b1}};
	localparam int RANDOM_WORDS = 700;
	localparam int PHASE_COUNT  = 4;

	// Sorted shadow of the queue; predicts one response word per request word
	class pq_scoreboard;
		entry_t      shadow_slots[$];
		result_t     expected_words[$];
		int unsigned mismatches;

		function void note_request(op_t op, logic [KEY_FIELD_W-1:0] key,
			logic [PAY_FIELD_W-1:0] payload);
			result_t r;
			entry_t  e;
			int      pos;
			r = '0;
			r.status = ST_DONE;
			case (op)
				OP_ENQUEUE: begin
					if (shadow_slots.size() >= CAPACITY) begin
						r.status = ST_FULL;
					end else begin
						e.key = key;
						e.payload = payload;
						// equal keys go behind the ones already stored
						pos = 0;
						while (pos < shadow_slots.size() && shadow_slots[pos].key <= e.key)
							pos++;
						shadow_slots.insert(pos, e);
					end
				end
				OP_DEQUEUE: begin
					if (shadow_slots.size() == 0) begin
						r.status = ST_EMPTY;
					end else begin
						e = shadow_slots.pop_front();
						r.removed_valid = 1'b1;
						r.removed_key = e.key;
						r.removed_payload = e.payload;
					end
				end
				OP_CLEAR: begin
					shadow_slots.delete();
				end
				default: begin
				end
			endcase
			r.entry_count = CNT_FIELD_W'(shadow_slots.size());
			r.is_full = (shadow_slots.size() == CAPACITY);
			r.is_empty = (shadow_slots.size() == 0);
			expected_words.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
			if (want !== seen) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				mismatches++;
			end
		endfunction

		function void check_response(result_t seen);
			result_t want;
			if (expected_words.size() == 0) begin
				$error("response word with none expected: status 0x%0h count 0x%0h",
					seen.status, seen.entry_count);
				mismatches++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("status", 64'(want.status), 64'(seen.status));
			compare_field("removed_valid", 64'(want.removed_valid), 64'(seen.removed_valid));
			compare_field("removed_key", 64'(want.removed_key), 64'(seen.removed_key));
			compare_field("removed_payload", 64'(want.removed_payload),
				64'(seen.removed_payload));
			compare_field("entry_count", 64'(want.entry_count), 64'(seen.entry_count));
			compare_field("is_full", 64'(want.is_full), 64'(seen.is_full));
			compare_field("is_empty", 64'(want.is_empty), 64'(seen.is_empty));
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bsp_req_if req_ch();
	bsp_rsp_if rsp_ch();

	pq_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;

	bounded_sorted_priority_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up long after the slowest correct run
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Stall the response channel at random; hold it low during reset
	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && !chance(recv_stall_pct);
	end

	// Note accepted requests, check accepted responses
	always @(posedge clk) begin
		result_t seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.status = status_t'(rsp_ch.status);
				seen.removed_valid = rsp_ch.removed_valid;
				seen.removed_key = rsp_ch.removed_key;
				seen.removed_payload = rsp_ch.removed_payload;
				seen.entry_count = rsp_ch.entry_count;
				seen.is_full = rsp_ch.is_full;
				seen.is_empty = rsp_ch.is_empty;
				sb.check_response(seen);
			end
			if (req_ch.valid && req_ch.ready)
				sb.note_request(op_t'(req_ch.op), req_ch.entry_key, req_ch.entry_payload);
		end
	end

	// Offer one request word and hold it until taken
	task automatic send_word(op_t op, logic [KEY_FIELD_W-1:0] key,
		logic [PAY_FIELD_W-1:0] payload);
		while (chance(send_idle_pct)) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.entry_key <= key;
		req_ch.entry_payload <= payload;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Hold off the sender until every response word has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_word(OP_CLEAR, '0, '0);
		send_word(OP_DEQUEUE, KEY_MAX, PAY_MAX);
		send_word(OP_NONE, KEY_MAX, PAY_MAX);
		send_word(OP_ENQUEUE, KEY_MAX, PAY_MAX);
		send_word(OP_ENQUEUE, '0, '0);
		// three equal keys must leave in arrival order
		send_word(OP_ENQUEUE, 40'd5, 16'd1);
		send_word(OP_ENQUEUE, 40'd5, 16'd2);
		send_word(OP_ENQUEUE, 40'd5, 16'd3);
		send_word(OP_ENQUEUE, 40'h55_5555_5555, 16'h5555);
		send_word(OP_ENQUEUE, 40'hAA_AAAA_AAAA, 16'hAAAA);
		send_word(OP_ENQUEUE, KEY_MAX, 16'h1234);
		// queue is full now
		send_word(OP_ENQUEUE, 40'd1, 16'h0F0F);
		send_word(OP_NONE, '0, '0);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_CLEAR, '0, '0);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_ENQUEUE, 40'h80_0000_0001, 16'h8001);
		send_word(OP_DEQUEUE, '0, '0);
	endtask

	// Mix of fill-heavy, drain-heavy and balanced runs with random content
	task automatic run_random(int words);
		int                     enq_pct;
		int                     roll;
		op_t                    op;
		logic [KEY_FIELD_W-1:0] key;
		logic [PAY_FIELD_W-1:0] payload;
		for (int n = 0; n < words; n++) begin
			if (n % 20 == 0) begin
				case ($urandom_range(0, 2))
					0: enq_pct = 75;
					1: enq_pct = 25;
					default: enq_pct = 50;
				endcase
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_CLEAR;
			else if (roll < 5)
				op = OP_NONE;
			else if (roll < 5 + (enq_pct * 95) / 100)
				op = OP_ENQUEUE;
			else
				op = OP_DEQUEUE;
			// narrow keys force ties, wide keys exercise every bit
			if (chance(50))
				key = KEY_FIELD_W'($urandom_range(0, 7));
			else
				key = {8'($urandom_range(0, 255)), 32'($urandom())};
			payload = PAY_FIELD_W'($urandom_range(0, 65535));
			send_word(op, key, payload);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		req_ch.valid <= 1'b0;
		req_ch.op <= OP_NONE;
		req_ch.entry_key <= '0;
		req_ch.entry_payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 49;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 49;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			run_random(RANDOM_WORDS / PHASE_COUNT);
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bsp_pkg.sv
hw/rtl/bsp_req_if.sv
hw/rtl/bsp_rsp_if.sv
hw/rtl/bsp_cell.sv
hw/rtl/bounded_sorted_priority_queue_top.sv
dv/tb_bounded_sorted_priority_queue_top.sv
